[hw/rtl/cdv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdv_pkg - shared types and constants of the command datagram validator
// Holds the parse phase encoding, the byte item and the result record that
// travel between the input register, the frame parser and the result register.
// ----------------------------------------------------------------------------
package cdv_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned TextW  = 17;
  localparam int unsigned StrW   = 9;

  // text byte counter saturates here; any count above 65535 mismatches
  localparam logic [TextW-1:0] TEXT_SEEN_MAX = {TextW{1'b1}};

  typedef enum logic [2:0] {
    PH_SKIP  = 3'd0,
    PH_THI   = 3'd1,
    PH_TLO   = 3'd2,
    PH_COUNT = 3'd3,
    PH_STR   = 3'd4,
    PH_BHI   = 3'd5,
    PH_BLO   = 3'd6,
    PH_PAY   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             valid_res;
    logic [ByteW-1:0] param_count;
    logic [SizeW-1:0] text_size;
    logic [SizeW-1:0] binary_size;
    logic             has_binary;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/command_datagram_validator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// command_datagram_validator - framing check for byte-serial command datagrams
// Skips lead_skip bytes, decodes the text size, parameter count, strings and
// optional binary part, and reports one result on the last byte.
// ----------------------------------------------------------------------------
// Takes one datagram byte per clock unless in_stall is raised: each byte passes
// an input register, then updates the parse counters, and on the byte flagged
// last_byte its result is loaded into the output register. A stalled result
// holds back only the last byte of the next datagram; other bytes keep flowing.
// lead_skip is written through the cfg channel, which is always ready, and
// must only change between datagrams.
module command_datagram_validator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  lead_skip,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_in,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             valid_res,
  output logic [7:0]       param_count,
  output logic [15:0]      text_size,
  output logic [15:0]      binary_size,
  output logic             has_binary
);
  import cdv_pkg::*;

  logic [ByteW-1:0] skip_limit;
  item_t            in_item;
  item_t            held_item;
  logic             held_valid;
  logic             take;
  logic             can_load;
  logic             res_load;
  result_t          res;
  result_t          res_out;

  assign cfg_ready = 1'b1;

  // hold the skip count register
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      skip_limit <= lead_skip;
    end
  end

  assign in_item.data = byte_in;
  assign in_item.last = last_byte;

  // a last byte waits for room in the result register
  assign take = held_valid && (!held_item.last || can_load);

  cdv_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .take      (take),
    .held_valid(held_valid),
    .held_item (held_item)
  );

  cdv_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .skip_limit(skip_limit),
    .take      (take),
    .item      (held_item),
    .res_load  (res_load),
    .res       (res)
  );

  cdv_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .res_in   (res),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res_out  (res_out)
  );

  assign valid_res   = res_out.valid_res;
  assign param_count = res_out.param_count;
  assign text_size   = res_out.text_size;
  assign binary_size = res_out.binary_size;
  assign has_binary  = res_out.has_binary;

  // never overwrite a result that is still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled result");

  // a held last byte is blocked only by a stalled result
  a_last_block: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !take) |-> (held_item.last && out_valid && out_stall))
    else $error("byte held without cause");

  // reported binary size is zero whenever no binary part is flagged
  a_bin_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_binary) |-> (binary_size == '0))
    else $error("binary size without binary part");

endmodule
`default_nettype wire

[hw/rtl/cdv_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdv_in_reg - input register of the validator
// Captures one datagram byte per transfer and hands it to the parser when the
// parser can take it; refills in the same cycle it drains.
// ----------------------------------------------------------------------------
module cdv_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire cdv_pkg::item_t in_item,
  input  wire logic          take,
  output logic               held_valid,
  output cdv_pkg::item_t     held_item
);
  import cdv_pkg::*;

  logic load;

  // accept when empty or draining this cycle
  assign in_stall = held_valid && !take;
  assign load     = in_valid && !in_stall;

  // track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cdv_frame.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdv_frame - datagram frame parser
// Walks the skip bytes, the size header, the zero-terminated strings and the
// optional binary part one byte at a time, and builds the result record on
// the byte that ends the datagram.
// ----------------------------------------------------------------------------
module cdv_frame (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [cdv_pkg::ByteW-1:0] skip_limit,
  input  wire logic                   take,
  input  wire cdv_pkg::item_t         item,
  output logic                        res_load,
  output cdv_pkg::result_t            res
);
  import cdv_pkg::*;

  phase_t           phase, phase_next;
  logic [ByteW-1:0] skip_seen, skip_seen_next;
  logic [SizeW-1:0] declared_text, declared_text_next;
  logic [TextW-1:0] text_seen, text_seen_next;
  logic [ByteW-1:0] count_byte, count_byte_next;
  logic [StrW-1:0]  strings_left, strings_left_next;
  logic [SizeW-1:0] declared_binary, declared_binary_next;
  logic [SizeW-1:0] binary_seen, binary_seen_next;
  logic             error_mark, error_mark_next;
  phase_t           work_phase;
  logic             consume;
  logic [StrW-1:0]  str_dec;
  logic             bin;

  // next frame state for the byte at hand
  always_comb begin
    phase_next           = phase;
    skip_seen_next       = skip_seen;
    declared_text_next   = declared_text;
    text_seen_next       = text_seen;
    count_byte_next      = count_byte;
    strings_left_next    = strings_left;
    declared_binary_next = declared_binary;
    binary_seen_next     = binary_seen;
    error_mark_next      = error_mark;
    work_phase           = phase;
    consume              = 1'b1;
    str_dec              = strings_left;

    // drop leading bytes until the limit is met, then fall into the header
    if (phase == PH_SKIP) begin
      if (skip_seen < skip_limit) begin
        skip_seen_next = skip_seen + ByteW'(1);
        consume        = 1'b0;
      end else begin
        work_phase = PH_THI;
      end
    end

    if (consume) begin
      unique case (work_phase)
        PH_THI: begin
          declared_text_next = {item.data, {ByteW{1'b0}}};
          phase_next         = PH_TLO;
        end
        PH_TLO: begin
          declared_text_next = {declared_text[SizeW-1:ByteW], item.data};
          phase_next         = PH_COUNT;
        end
        PH_COUNT: begin
          count_byte_next   = item.data;
          strings_left_next = {1'b0, item.data} + StrW'(1);
          text_seen_next    = TextW'(1);
          phase_next        = PH_STR;
        end
        PH_STR: begin
          if (text_seen != TEXT_SEEN_MAX) begin
            text_seen_next = text_seen + TextW'(1);
          end
          // a terminator closes one string; the last one checks the size
          if (item.data == '0) begin
            if (strings_left != '0) begin
              str_dec = strings_left - StrW'(1);
            end
            strings_left_next = str_dec;
            if (str_dec == '0) begin
              if (text_seen_next != {1'b0, declared_text}) begin
                error_mark_next = 1'b1;
              end
              phase_next = PH_BHI;
            end
          end
        end
        PH_BHI: begin
          declared_binary_next = {item.data, {ByteW{1'b0}}};
          phase_next           = PH_BLO;
        end
        PH_BLO: begin
          declared_binary_next = {declared_binary[SizeW-1:ByteW], item.data};
          binary_seen_next     = '0;
          phase_next           = PH_PAY;
        end
        PH_PAY: begin
          if (binary_seen < declared_binary) begin
            binary_seen_next = binary_seen + SizeW'(1);
          end else begin
            error_mark_next = 1'b1;
          end
        end
        default: begin
          error_mark_next = 1'b1;
        end
      endcase
    end
  end

  // build the result from the updated state
  always_comb begin
    bin             = (phase_next == PH_PAY);
    res_load        = take && item.last;
    res.valid_res   = !error_mark_next &&
                      ((phase_next == PH_BHI) ||
                       (bin && (binary_seen_next == declared_binary_next)));
    res.param_count = count_byte_next;
    res.text_size   = declared_text_next;
    res.binary_size = bin ? declared_binary_next : '0;
    res.has_binary  = bin;
  end

  // control state: advance per byte, drop back to skip after a datagram
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SKIP;
      skip_seen    <= '0;
      strings_left <= '0;
      error_mark   <= 1'b0;
      text_seen    <= '0;
      binary_seen  <= '0;
    end else if (take) begin
      if (item.last) begin
        phase        <= PH_SKIP;
        skip_seen    <= '0;
        strings_left <= '0;
        error_mark   <= 1'b0;
        text_seen    <= '0;
        binary_seen  <= '0;
      end else begin
        phase        <= phase_next;
        skip_seen    <= skip_seen_next;
        strings_left <= strings_left_next;
        error_mark   <= error_mark_next;
        text_seen    <= text_seen_next;
        binary_seen  <= binary_seen_next;
      end
    end
  end

  // decoded header fields: cleared between datagrams since they are reported
  always_ff @(posedge clk) begin
    if (rst) begin
      declared_text   <= '0;
      count_byte      <= '0;
      declared_binary <= '0;
    end else if (take) begin
      if (item.last) begin
        declared_text   <= '0;
        count_byte      <= '0;
        declared_binary <= '0;
      end else begin
        declared_text   <= declared_text_next;
        count_byte      <= count_byte_next;
        declared_binary <= declared_binary_next;
      end
    end
  end

  // a finished datagram leaves the parser in the skip phase
  a_restart: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (phase == PH_SKIP) && (skip_seen == '0) && !error_mark)
    else $error("parser did not restart after a datagram");

  // the string phase always has a string still open
  a_str_open: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_STR) |-> (strings_left != '0) && (text_seen != '0))
    else $error("string phase with no open string");

  // payload count never passes the declared size
  a_pay_bound: assert property (@(posedge clk) disable iff (rst)
    binary_seen <= declared_binary)
    else $error("payload count beyond declared size");

  // state only moves when a byte is taken
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(phase) && $stable(skip_seen) && $stable(text_seen))
    else $error("parser state moved without a byte");

endmodule
`default_nettype wire

[hw/rtl/cdv_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdv_out_reg - result register of the validator
// Holds one result record until the receiver takes it and reports whether a
// new record can be loaded this cycle.
// ----------------------------------------------------------------------------
module cdv_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire cdv_pkg::result_t res_in,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output cdv_pkg::result_t      res_out
);
  import cdv_pkg::*;

  // free when empty or the held result transfers now
  assign can_load = !out_valid || !out_stall;

  // track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule
`default_nettype wire

[tb/command_datagram_validator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_datagram_validator_test - self-checking bench for the datagram check
// Streams skip bytes, headers, strings and binary parts through the validator
// under several lead_skip settings and idle/stall mixes. A frame checker
// parses every accepted byte on its own and compares each returned result
// field by field, in order.
// ----------------------------------------------------------------------------
module command_datagram_validator_test;
  import cdv_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  // Parse each accepted byte and queue the result a datagram end produces.
  class frame_checker;
    result_t          pending_results[$];
    int               errors;
    int               results_seen;
    int               valid_seen;
    int               binary_frames;
    int               bytes_taken;
    logic [7:0]       skip_len;
    phase_t           phase;
    logic [7:0]       skip_seen;
    logic [15:0]      declared_text;
    logic [16:0]      text_seen;
    logic [7:0]       count_byte;
    logic [8:0]       strings_left;
    logic [15:0]      declared_binary;
    logic [16:0]      binary_seen;
    logic             error_mark;

    function new();
      errors = 0;
      results_seen = 0;
      valid_seen = 0;
      binary_frames = 0;
      bytes_taken = 0;
      skip_len = 8'd0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase = PH_SKIP;
      skip_seen = 8'd0;
      declared_text = 16'd0;
      text_seen = 17'd0;
      count_byte = 8'd0;
      strings_left = 9'd0;
      declared_binary = 16'd0;
      binary_seen = 17'd0;
      error_mark = 1'b0;
    endfunction

    function void write_skip(logic [7:0] value);
      skip_len = value;
    endfunction

    function void report(string msg);
      if (errors < 30) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      errors++;
    endfunction

    function void parse_byte(logic [7:0] b);
      // drop leading bytes until the skip count is reached
      if (phase == PH_SKIP) begin
        if (skip_seen < skip_len) begin
          skip_seen = skip_seen + 8'd1;
          return;
        end
        phase = PH_THI;
      end
      case (phase)
        PH_THI: begin
          declared_text = {b, 8'h00};
          phase = PH_TLO;
        end
        PH_TLO: begin
          declared_text[7:0] = b;
          phase = PH_COUNT;
        end
        PH_COUNT: begin
          count_byte = b;
          strings_left = {1'b0, b} + 9'd1;
          text_seen = 17'd1;
          phase = PH_STR;
        end
        PH_STR: begin
          if (text_seen != TEXT_SEEN_MAX) text_seen = text_seen + 17'd1;
          if (b == 8'd0) begin
            if (strings_left != 9'd0) strings_left = strings_left - 9'd1;
            if (strings_left == 9'd0) begin
              if (text_seen != {1'b0, declared_text}) error_mark = 1'b1;
              phase = PH_BHI;
            end
          end
        end
        PH_BHI: begin
          declared_binary = {b, 8'h00};
          phase = PH_BLO;
        end
        PH_BLO: begin
          declared_binary[7:0] = b;
          binary_seen = 17'd0;
          phase = PH_PAY;
        end
        PH_PAY: begin
          if (binary_seen < {1'b0, declared_binary}) binary_seen = binary_seen + 17'd1;
          else error_mark = 1'b1;
        end
        default: error_mark = 1'b1;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      result_t r;
      bytes_taken++;
      parse_byte(b);
      if (last) begin
        r.has_binary  = (phase == PH_PAY);
        r.valid_res   = !error_mark &&
                        (phase == PH_BHI ||
                         (r.has_binary && binary_seen == {1'b0, declared_binary}));
        r.param_count = count_byte;
        r.text_size   = declared_text;
        r.binary_size = r.has_binary ? declared_binary : 16'd0;
        pending_results.push_back(r);
        clear_frame();
      end
    endfunction

    function void compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s got %0h expected %0h",
                         results_seen, name, got, want));
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %0h", got));
        return;
      end
      want = pending_results.pop_front();
      compare_field("valid_res", 16'(got.valid_res), 16'(want.valid_res));
      compare_field("param_count", 16'(got.param_count), 16'(want.param_count));
      compare_field("text_size", got.text_size, want.text_size);
      compare_field("binary_size", got.binary_size, want.binary_size);
      compare_field("has_binary", 16'(got.has_binary), 16'(want.has_binary));
      results_seen++;
      if (want.valid_res) valid_seen++;
      if (want.has_binary) binary_frames++;
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  lead_skip = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_in = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        valid_res;
  logic [7:0]  param_count;
  logic [15:0] text_size;
  logic [15:0] binary_size;
  logic        has_binary;
  result_t     seen_res;

  frame_checker board;
  logic [7:0]   frame_q[$];
  int           in_idle_pct = 0;
  int           out_stall_pct = 0;
  int           quiet_cycles = 0;

  command_datagram_validator uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .lead_skip   (lead_skip),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_in     (byte_in),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .valid_res   (valid_res),
    .param_count (param_count),
    .text_size   (text_size),
    .binary_size (binary_size),
    .has_binary  (has_binary)
  );

  assign seen_res = {valid_res, param_count, text_size, binary_size, has_binary};

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Track every transfer and end the run if traffic stops.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.write_skip(lead_skip);
      if (in_valid && !in_stall) board.note_byte(byte_in, last_byte);
      if (out_valid && !out_stall) board.check_result(seen_res);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
          (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no transfer for %0d cycles, %0d results pending",
                   quiet_cycles, board.pending_results.size());
          $display("** command_datagram_validator: FAILED **");
          $finish;
        end
      end
    end
  end

  // Drive one byte, idling first at random; hold until the transfer.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    byte_in   <= b;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Release the input and wait until every expected result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_lead_skip(input logic [7:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    lead_skip <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Assemble a datagram: skip bytes, header, count+1 strings, optional binary
  // part. A negative cut truncates at a random point.
  task automatic build_frame(input int n_params, input int str_max,
                             input logic [15:0] text_delta, input bit with_bin,
                             input logic [15:0] bin_len, input int pay_extra,
                             input int cut);
    int          skip;
    int          text_len;
    int          pay_len;
    int          n;
    logic [15:0] size16;
    frame_q.delete();
    skip = board.skip_len;
    repeat (skip) frame_q.push_back(8'($urandom_range(255)));
    frame_q.push_back(8'd0);
    frame_q.push_back(8'd0);
    frame_q.push_back(8'(n_params));
    text_len = 1;
    for (int i = 0; i <= n_params; i++) begin
      n = $urandom_range(str_max, 0);
      repeat (n) frame_q.push_back(8'($urandom_range(255, 1)));
      frame_q.push_back(8'd0);
      text_len += n + 1;
    end
    size16 = 16'(text_len) + text_delta;
    frame_q[skip]     = size16[15:8];
    frame_q[skip + 1] = size16[7:0];
    if (with_bin) begin
      frame_q.push_back(bin_len[15:8]);
      frame_q.push_back(bin_len[7:0]);
      pay_len = int'(bin_len) + pay_extra;
      if (pay_len < 0) pay_len = 0;
      repeat (pay_len) frame_q.push_back(8'($urandom_range(255)));
    end
    if (cut < 0 && frame_q.size() > 1) cut = $urandom_range(frame_q.size() - 1, 1);
    while (cut > 0 && frame_q.size() > 1) begin
      void'(frame_q.pop_back());
      cut--;
    end
  endtask

  // Mostly well-formed frames with random content; the rest broken or noise.
  task automatic random_frame();
    int          kind;
    int          np;
    int          str_max;
    bit          with_bin;
    logic [15:0] bin_len;
    kind = $urandom_range(99);
    if ($urandom_range(29) == 0) begin
      np = $urandom_range(20, 4);
      str_max = 1;
    end else begin
      np = $urandom_range(3);
      str_max = 5;
    end
    with_bin = $urandom_range(1);
    bin_len = 16'($urandom_range(6));
    if (kind < 60) begin
      build_frame(np, str_max, 16'd0, with_bin, bin_len, 0, 0);
    end else if (kind < 70) begin
      build_frame(np, str_max, 16'($urandom_range(65535, 1)), with_bin, bin_len, 0, 0);
    end else if (kind < 80) begin
      build_frame(np, str_max, 16'd0, with_bin, bin_len, 0, -1);
    end else if (kind < 88) begin
      build_frame(np, str_max, 16'd0, 1'b1, bin_len, $urandom_range(3, 1), 0);
    end else if (kind < 93) begin
      bin_len = 16'($urandom_range(65535));
      build_frame(np, str_max, 16'd0, 1'b1, bin_len,
                  $urandom_range(3) - int'(bin_len), 0);
    end else begin
      frame_q.delete();
      repeat ($urandom_range(10, 1)) frame_q.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic random_part(input int byte_target, input int frame_target,
                             input int pause_every);
    int sent;
    int frames;
    sent = 0;
    frames = 0;
    while (sent < byte_target || frames < frame_target) begin
      if (pause_every > 0 && frames % pause_every == pause_every - 1) wait_drained();
      random_frame();
      send_frame();
      if (frame_q.size() > board.skip_len) sent += frame_q.size() - board.skip_len;
      frames++;
    end
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: minimal frame, binary part, size mismatch, cut-short and payload length cases
    build_frame(0, 0, 16'd0, 1'b0, 16'd0, 0, 0);
    send_frame();
    build_frame(1, 1, 16'd0, 1'b1, 16'd1, 0, 0);
    send_frame();
    build_frame(0, 0, 16'hFFFF, 1'b0, 16'd0, 0, 0);
    send_frame();
    build_frame(0, 0, 16'hA500, 1'b0, 16'd0, 0, 3);
    send_frame();
    build_frame(0, 0, 16'd0, 1'b1, 16'd3, 0, 4);
    send_frame();
    build_frame(0, 0, 16'd0, 1'b1, 16'd0, 1, 0);
    send_frame();
    build_frame(0, 0, 16'd0, 1'b1, 16'd2, -1, 0);
    send_frame();
    // full parameter count, cut after six empty strings
    build_frame(255, 0, 16'd0, 1'b0, 16'd0, 0, 250);
    send_frame();

    // no idling
    write_lead_skip(8'd0);
    random_part(80, 0, 0);

    // sender idles, largest skip
    in_idle_pct = 61;
    write_lead_skip(8'd255);
    random_part(0, 1, 0);

    // receiver stalls
    in_idle_pct = 0;
    out_stall_pct = 61;
    write_lead_skip(8'd1);
    random_part(50, 0, 0);

    // both sides idle, with a full drain now and then
    in_idle_pct = 31;
    out_stall_pct = 31;
    write_lead_skip(8'd3);
    random_part(50, 0, 4);

    write_lead_skip(8'($urandom_range(7, 2)));
    random_part(40, 0, 0);

    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    $display("Checked %0d results (%0d valid, %0d with binary part) from %0d bytes",
             board.results_seen, board.valid_seen, board.binary_frames,
             board.bytes_taken);
    $display("lead_skip 0 to 255, idle and stall mixes, truncation, excess payload, full count");
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("** command_datagram_validator: PASSED **");
    end else begin
      $display("** command_datagram_validator: FAILED **");
    end
    $finish;
  end

endmodule
